// ----- hdl/cau_pkg.sv -----
// Shared types, codes and arithmetic helpers of the complex arithmetic unit.
// No dependencies; every module of the unit imports this package, the interfaces do not.
package cau_pkg;

	localparam int DATA_W        = 32;
	localparam int MAG_W         = 64;
	localparam int QUO_W         = 35;
	localparam int ROOT_STEPS    = 32;
	localparam int QUEUE_DEPTH   = 4;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;
	localparam logic [1:0] MODE_DIV = 2'd3;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_OVF  = 2'd1;
	localparam logic [1:0] STATUS_DIVZ = 2'd2;

	// what the back end still has to do with a queued item
	localparam logic [1:0] KIND_DONE = 2'd0;
	localparam logic [1:0] KIND_DIV  = 2'd1;
	localparam logic [1:0] KIND_DIVZ = 2'd2;

	localparam logic [35:0] QUO_CLAMP = 36'h4_0000_0000;

	typedef struct packed {
		logic [1:0]         kind;
		logic               re_neg;
		logic               im_neg;
		logic [MAG_W-1:0]   re_mag;
		logic [MAG_W-1:0]   im_mag;
		logic [MAG_W-1:0]   den;
		logic [DATA_W-1:0]  res_re;
		logic [DATA_W-1:0]  res_im;
		logic               ovf;
	} cau_entry_t;

	typedef struct packed {
		logic [MAG_W-1:0] r;
		logic [QUO_W-1:0] q;
	} div_rq_t;

	typedef struct packed {
		logic [MAG_W-1:0] n;
		logic [MAG_W-1:0] r;
	} sqrt_nr_t;

	// saturate a sign/magnitude value to 32 bits; bit 32 flags saturation
	function automatic logic [DATA_W:0] sat32(input logic neg, input logic [MAG_W-1:0] mag);
		logic [DATA_W:0] res;
		if (!neg) begin
			if (mag > 64'h7FFF_FFFF) res = {1'b1, 32'h7FFF_FFFF};
			else res = {1'b0, mag[DATA_W-1:0]};
		end else begin
			if (mag > 64'h8000_0000) res = {1'b1, 32'h8000_0000};
			else res = {1'b0, 32'd0 - mag[DATA_W-1:0]};
		end
		return res;
	endfunction

	// one restoring division step with the quotient clamped at 2^34
	function automatic div_rq_t div_step(input logic [MAG_W-1:0] r, input logic [QUO_W-1:0] q,
			input logic nbit, input logic [MAG_W-1:0] den);
		logic [MAG_W:0] t;
		logic [QUO_W:0] qn;
		div_rq_t o;
		t  = {r, nbit};
		qn = {q, 1'b0};
		if (t >= {1'b0, den}) begin
			t     = t - {1'b0, den};
			qn[0] = 1'b1;
		end
		if (qn > QUO_CLAMP) qn = QUO_CLAMP;
		o.r = t[MAG_W-1:0];
		o.q = qn[QUO_W-1:0];
		return o;
	endfunction

	// one step of the digit-by-digit integer square root
	function automatic sqrt_nr_t sqrt_step(input logic [MAG_W-1:0] n, input logic [MAG_W-1:0] r,
			input logic [MAG_W-1:0] sbit);
		logic [MAG_W:0] t;
		sqrt_nr_t o;
		t = {1'b0, r} + {1'b0, sbit};
		if ({1'b0, n} >= t) begin
			o.n = n - t[MAG_W-1:0];
			o.r = (r >> 1) + sbit;
		end else begin
			o.n = n;
			o.r = r >> 1;
		end
		return o;
	endfunction

endpackage

// ----- hdl/cau_if.sv -----
// Valid/ready channel interfaces of the complex arithmetic unit.
// No dependencies.
interface cau_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [31:0] a_real;
	logic signed [31:0] a_imag;
	logic signed [31:0] b_real;
	logic signed [31:0] b_imag;

	modport source(output valid, mode, a_real, a_imag, b_real, b_imag, input ready);
	modport sink(input valid, mode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] res_real;
	logic signed [31:0] res_imag;
	logic [30:0]        res_magnitude;
	logic [1:0]         status;

	modport source(output valid, res_real, res_imag, res_magnitude, status, input ready);
	modport sink(input valid, res_real, res_imag, res_magnitude, status, output ready);
endinterface

// ----- hdl/cau_front.sv -----
// Front end: takes input transfers, forms products and sums, classifies the item.
// Depends on cau_pkg and cau_in_if; feeds cau_queue.
module cau_front #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	cau_in_if.sink             in_ch,
	input  logic               full,
	output logic               push,
	output cau_pkg::cau_entry_t entry
);
	import cau_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [1:0]         mode_s1;
	logic signed [31:0] ar_s1, ai_s1, br_s1, bi_s1;

	logic [1:0]         mode_s2;
	logic               bzero_s2;
	logic signed [63:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, q_rr_s2, q_ii_s2;
	logic signed [32:0] lin_re_s2, lin_im_s2;

	logic [1:0]         mode_s3;
	logic               bzero_s3;
	logic signed [64:0] re_sum_s3, im_sum_s3;
	logic [MAG_W-1:0]   den_s3;
	logic [DATA_W:0]    lin_re_s3, lin_im_s3;

	logic [1:0]         mode_s4;
	logic               bzero_s4;
	logic               re_neg_s4, im_neg_s4;
	logic [MAG_W-1:0]   re_mag_s4, im_mag_s4, den_s4;
	logic [DATA_W:0]    lin_re_s4, lin_im_s4;

	cau_entry_t entry_s5;

	logic [32:0]      lin_re_mag, lin_im_mag;
	logic [64:0]      re_mag_w, im_mag_w;
	logic [MAG_W-1:0] mul_re_m, mul_im_m;
	logic [DATA_W:0]  mul_re_sat, mul_im_sat;

	assign en          = !v_s5 || !full;
	assign in_ch.ready = en;
	assign push        = v_s5 && en;
	assign entry       = entry_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= in_ch.mode;
			ar_s1   <= in_ch.a_real;
			ai_s1   <= in_ch.a_imag;
			br_s1   <= in_ch.b_real;
			bi_s1   <= in_ch.b_imag;
		end
	end

	// stage 2: all products needed by either multiply or divide, and the add/subtract sums
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2  <= mode_s1;
			bzero_s2 <= (br_s1 == '0) && (bi_s1 == '0);
			p_rr_s2  <= ar_s1 * br_s1;
			p_ii_s2  <= ai_s1 * bi_s1;
			p_ri_s2  <= ar_s1 * bi_s1;
			p_ir_s2  <= ai_s1 * br_s1;
			q_rr_s2  <= br_s1 * br_s1;
			q_ii_s2  <= bi_s1 * bi_s1;
			if (mode_s1 == MODE_SUB) begin
				lin_re_s2 <= {ar_s1[31], ar_s1} - {br_s1[31], br_s1};
				lin_im_s2 <= {ai_s1[31], ai_s1} - {bi_s1[31], bi_s1};
			end else begin
				lin_re_s2 <= {ar_s1[31], ar_s1} + {br_s1[31], br_s1};
				lin_im_s2 <= {ai_s1[31], ai_s1} + {bi_s1[31], bi_s1};
			end
		end
	end

	assign lin_re_mag = lin_re_s2[32] ? 33'(-lin_re_s2) : 33'(lin_re_s2);
	assign lin_im_mag = lin_im_s2[32] ? 33'(-lin_im_s2) : 33'(lin_im_s2);

	// stage 3: product sums, divisor norm, saturated add/subtract results
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3   <= mode_s2;
			bzero_s3  <= bzero_s2;
			den_s3    <= 64'(q_rr_s2) + 64'(q_ii_s2);
			lin_re_s3 <= sat32(lin_re_s2[32], 64'(lin_re_mag));
			lin_im_s3 <= sat32(lin_im_s2[32], 64'(lin_im_mag));
			if (mode_s2 == MODE_MUL) begin
				re_sum_s3 <= {p_rr_s2[63], p_rr_s2} - {p_ii_s2[63], p_ii_s2};
				im_sum_s3 <= {p_ri_s2[63], p_ri_s2} + {p_ir_s2[63], p_ir_s2};
			end else begin
				re_sum_s3 <= {p_rr_s2[63], p_rr_s2} + {p_ii_s2[63], p_ii_s2};
				im_sum_s3 <= {p_ir_s2[63], p_ir_s2} - {p_ri_s2[63], p_ri_s2};
			end
		end
	end

	assign re_mag_w = re_sum_s3[64] ? 65'(-re_sum_s3) : 65'(re_sum_s3);
	assign im_mag_w = im_sum_s3[64] ? 65'(-im_sum_s3) : 65'(im_sum_s3);

	// stage 4: sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s4   <= mode_s3;
			bzero_s4  <= bzero_s3;
			den_s4    <= den_s3;
			lin_re_s4 <= lin_re_s3;
			lin_im_s4 <= lin_im_s3;
			re_neg_s4 <= re_sum_s3[64];
			im_neg_s4 <= im_sum_s3[64];
			re_mag_s4 <= re_mag_w[MAG_W-1:0];
			im_mag_s4 <= im_mag_w[MAG_W-1:0];
		end
	end

	assign mul_re_m   = (re_mag_s4 >> FRAC_BITS) + MAG_W'(re_mag_s4[FRAC_BITS-1]);
	assign mul_im_m   = (im_mag_s4 >> FRAC_BITS) + MAG_W'(im_mag_s4[FRAC_BITS-1]);
	assign mul_re_sat = sat32(re_neg_s4, mul_re_m);
	assign mul_im_sat = sat32(im_neg_s4, mul_im_m);

	// stage 5: round and saturate products, classify
	always_ff @(posedge clk) begin
		if (en) begin
			entry_s5.re_neg <= re_neg_s4;
			entry_s5.im_neg <= im_neg_s4;
			entry_s5.re_mag <= re_mag_s4;
			entry_s5.im_mag <= im_mag_s4;
			entry_s5.den    <= den_s4;
			case (mode_s4)
				MODE_MUL: begin
					entry_s5.kind   <= KIND_DONE;
					entry_s5.res_re <= mul_re_sat[DATA_W-1:0];
					entry_s5.res_im <= mul_im_sat[DATA_W-1:0];
					entry_s5.ovf    <= mul_re_sat[DATA_W] || mul_im_sat[DATA_W];
				end
				MODE_DIV: begin
					entry_s5.kind   <= bzero_s4 ? KIND_DIVZ : KIND_DIV;
					entry_s5.res_re <= '0;
					entry_s5.res_im <= '0;
					entry_s5.ovf    <= 1'b0;
				end
				default: begin
					entry_s5.kind   <= KIND_DONE;
					entry_s5.res_re <= lin_re_s4[DATA_W-1:0];
					entry_s5.res_im <= lin_im_s4[DATA_W-1:0];
					entry_s5.ovf    <= lin_re_s4[DATA_W] || lin_im_s4[DATA_W];
				end
			endcase
		end
	end

endmodule

// ----- hdl/cau_queue.sv -----
// Short queue between the front end and the back end.
// Depends on cau_pkg for the entry type.
module cau_queue #(
	parameter int DEPTH = cau_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cau_pkg::cau_entry_t wr_entry,
	input  logic                pop,
	output cau_pkg::cau_entry_t head,
	output logic                full,
	output logic                empty
);
	import cau_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cau_entry_t       slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= wr_entry;
	end

endmodule

// ----- hdl/cau_back.sv -----
// Back end: pipelined divider, result rounding, squared norm, pipelined square root.
// Depends on cau_pkg and cau_out_if; drains cau_queue.
module cau_back #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cau_pkg::cau_entry_t head,
	input  logic                empty,
	output logic                pop,
	cau_out_if.source           out_ch
);
	import cau_pkg::*;

	localparam int DIV_STEPS = MAG_W + FRAC_BITS + 1;

	typedef struct packed {
		logic [1:0]        kind;
		logic              re_neg;
		logic              im_neg;
		logic [MAG_W-1:0]  nre;
		logic [MAG_W-1:0]  nim;
		logic [MAG_W-1:0]  rre;
		logic [MAG_W-1:0]  rim;
		logic [QUO_W-1:0]  qre;
		logic [QUO_W-1:0]  qim;
		logic [MAG_W-1:0]  den;
		logic [DATA_W-1:0] res_re;
		logic [DATA_W-1:0] res_im;
		logic              ovf;
	} div_stage_t;

	typedef struct packed {
		logic [DATA_W-1:0] re;
		logic [DATA_W-1:0] im;
		logic              ovf;
		logic              divz;
		logic [MAG_W-1:0]  n;
		logic [MAG_W-1:0]  r;
	} root_stage_t;

	logic en;

	div_stage_t d_q [DIV_STEPS+1];
	logic       dv_q [DIV_STEPS+1];

	logic [DATA_W-1:0] re_f, im_f;
	logic              ovf_f, divz_f, v_f;

	logic [MAG_W-1:0]  sq_re_m, sq_im_m;
	logic [DATA_W-1:0] re_m, im_m;
	logic              ovf_m, divz_m, v_m;

	root_stage_t rt_q [ROOT_STEPS+1];
	logic        rv_q [ROOT_STEPS+1];

	logic        out_v_q;
	logic [31:0] out_re_q, out_im_q;
	logic [30:0] out_mag_q;
	logic [1:0]  out_status_q;

	logic [QUO_W:0]    qre_r, qim_r;
	logic [DATA_W:0]   div_re_sat, div_im_sat;
	root_stage_t       rt_last;
	logic              mag_ovf;

	assign en  = !out_v_q || out_ch.ready;
	assign pop = en && !empty;

	// load the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_q[0] <= 1'b0;
		else if (en) dv_q[0] <= pop;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q[0].kind   <= head.kind;
			d_q[0].re_neg <= head.re_neg;
			d_q[0].im_neg <= head.im_neg;
			d_q[0].nre    <= head.re_mag;
			d_q[0].nim    <= head.im_mag;
			d_q[0].rre    <= '0;
			d_q[0].rim    <= '0;
			d_q[0].qre    <= '0;
			d_q[0].qim    <= '0;
			d_q[0].den    <= head.den;
			d_q[0].res_re <= head.res_re;
			d_q[0].res_im <= head.res_im;
			d_q[0].ovf    <= head.ovf;
		end
	end

	// one quotient bit per stage for both parts
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		div_rq_t    st_re, st_im;
		div_stage_t nxt;

		assign st_re = div_step(d_q[k].rre, d_q[k].qre, d_q[k].nre[MAG_W-1], d_q[k].den);
		assign st_im = div_step(d_q[k].rim, d_q[k].qim, d_q[k].nim[MAG_W-1], d_q[k].den);

		always_comb begin
			nxt     = d_q[k];
			nxt.nre = d_q[k].nre << 1;
			nxt.nim = d_q[k].nim << 1;
			nxt.rre = st_re.r;
			nxt.rim = st_im.r;
			nxt.qre = st_re.q;
			nxt.qim = st_im.q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_q[k+1] <= 1'b0;
			else if (en) dv_q[k+1] <= dv_q[k];
		end

		always_ff @(posedge clk) begin
			if (en) d_q[k+1] <= nxt;
		end
	end

	assign qre_r      = ({1'b0, d_q[DIV_STEPS].qre} + 1'b1) >> 1;
	assign qim_r      = ({1'b0, d_q[DIV_STEPS].qim} + 1'b1) >> 1;
	assign div_re_sat = sat32(d_q[DIV_STEPS].re_neg && (qre_r != '0), 64'(qre_r));
	assign div_im_sat = sat32(d_q[DIV_STEPS].im_neg && (qim_r != '0), 64'(qim_r));

	// finish: pick the result parts for the item kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f <= 1'b0;
			v_m <= 1'b0;
		end else if (en) begin
			v_f <= dv_q[DIV_STEPS];
			v_m <= v_f;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (d_q[DIV_STEPS].kind)
				KIND_DIV: begin
					re_f   <= div_re_sat[DATA_W-1:0];
					im_f   <= div_im_sat[DATA_W-1:0];
					ovf_f  <= div_re_sat[DATA_W] || div_im_sat[DATA_W];
					divz_f <= 1'b0;
				end
				KIND_DIVZ: begin
					re_f   <= '0;
					im_f   <= '0;
					ovf_f  <= 1'b0;
					divz_f <= 1'b1;
				end
				default: begin
					re_f   <= d_q[DIV_STEPS].res_re;
					im_f   <= d_q[DIV_STEPS].res_im;
					ovf_f  <= d_q[DIV_STEPS].ovf;
					divz_f <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_re_m <= 64'($signed(re_f)) * 64'($signed(re_f));
			sq_im_m <= 64'($signed(im_f)) * 64'($signed(im_f));
			re_m    <= re_f;
			im_m    <= im_f;
			ovf_m   <= ovf_f;
			divz_m  <= divz_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_q[0] <= 1'b0;
		else if (en) rv_q[0] <= v_m;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_q[0].re   <= re_m;
			rt_q[0].im   <= im_m;
			rt_q[0].ovf  <= ovf_m;
			rt_q[0].divz <= divz_m;
			rt_q[0].n    <= sq_re_m + sq_im_m;
			rt_q[0].r    <= '0;
		end
	end

	// two radicand bits per stage
	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		localparam logic [MAG_W-1:0] SBIT = MAG_W'(1) << (MAG_W - 2 - 2 * k);
		sqrt_nr_t    st;
		root_stage_t nxt;

		assign st = sqrt_step(rt_q[k].n, rt_q[k].r, SBIT);

		always_comb begin
			nxt   = rt_q[k];
			nxt.n = st.n;
			nxt.r = st.r;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv_q[k+1] <= 1'b0;
			else if (en) rv_q[k+1] <= rv_q[k];
		end

		always_ff @(posedge clk) begin
			if (en) rt_q[k+1] <= nxt;
		end
	end

	assign rt_last = rt_q[ROOT_STEPS];
	assign mag_ovf = rt_last.r > 64'h7FFF_FFFF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= rv_q[ROOT_STEPS];
	end

	// hold the result until the sink takes the transfer
	always_ff @(posedge clk) begin
		if (en) begin
			out_re_q  <= rt_last.re;
			out_im_q  <= rt_last.im;
			out_mag_q <= mag_ovf ? 31'h7FFF_FFFF : rt_last.r[30:0];
			if (rt_last.divz) out_status_q <= STATUS_DIVZ;
			else if (rt_last.ovf || mag_ovf) out_status_q <= STATUS_OVF;
			else out_status_q <= STATUS_OK;
		end
	end

	assign out_ch.valid         = out_v_q;
	assign out_ch.res_real      = out_re_q;
	assign out_ch.res_imag      = out_im_q;
	assign out_ch.res_magnitude = out_mag_q;
	assign out_ch.status        = out_status_q;

endmodule

// ----- hdl/complex_arith_unit_top.sv -----
// Complex arithmetic unit: Q(32-FRAC_BITS).FRAC_BITS add, subtract, multiply, divide.
// An item passes the front end stages, the queue, the one-bit-per-stage divider,
// the 32-stage square root and the result register; Q16.16 by default.
// Throughput one item per cycle; a full result register stalls the back end.
// Reset clears all valid flags and the queue pointers; no clearing pass.
// Depends on cau_pkg, cau_if, cau_front, cau_queue and cau_back.
module complex_arith_unit_top #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cau_in_if.sink    in_ch,
	cau_out_if.source out_ch
);
	import cau_pkg::*;

	cau_entry_t push_entry, head;
	logic       push, pop, full, empty;

	cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.full  (full),
		.push  (push),
		.entry (push_entry)
	);

	cau_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(push_entry),
		.pop     (pop),
		.head    (head),
		.full    (full),
		.empty   (empty)
	);

	cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.empty (empty),
		.pop   (pop),
		.out_ch(out_ch)
	);

endmodule
